// ----- src/fdf_pkg.sv -----
// Shared types and constants for the direct-form FIR/IIR filter.
// No dependencies; every other file imports this package.
package fdf_pkg;

  localparam int CoefW         = 18;  // coefficients are Q2.15
  localparam int CoefFrac      = 15;
  localparam int TapIdxW       = 7;
  localparam int TapIdxRange   = 1 << TapIdxW;
  localparam int CmdW          = 2;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 8;
  localparam int TapsResetVal  = 16;

  typedef enum logic [CmdW-1:0] {
    CmdSample  = 2'd0,
    CmdLoadFwd = 2'd1,
    CmdLoadFb  = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTapsInUse = 2'd0,
    RegIirMode   = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // Control broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic               shift;
    logic               clear;
    logic               ld_fwd;
    logic               ld_fb;
    logic               y_load;
    logic               iir;
    logic [TapIdxW-1:0] tap_index;
  } cell_ctrl_t;

endpackage

// ----- src/fdf_if.sv -----
// Valid/ready channel interfaces of the filter: command input, result output
// and configuration write. Depends on fdf_pkg.
interface fdf_in_if import fdf_pkg::*; #(parameter int ValW = 18) ();
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic [TapIdxW-1:0]     tap_index;
  logic signed [ValW-1:0] value;

  modport source (output valid, command, tap_index, value, input ready);
  modport sink   (input valid, command, tap_index, value, output ready);
endinterface

interface fdf_out_if #(parameter int SampleW = 18) ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] filtered;
  logic                      saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

interface fdf_cfg_if import fdf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/fdf_cell.sv -----
// One tap of the filter chain: input/output history, both coefficients,
// registered tap term and the partial sum passed to the next cell. Uses fdf_pkg.
module fdf_cell import fdf_pkg::*; #(
  parameter int SampleW = 18,
  parameter int ValW    = 18,
  parameter int AccW    = 45,
  parameter int CntW    = 8,
  parameter int CellIdx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic [ValW-1:0]           value_i,
  input  logic [CntW-1:0]           n_i,
  input  logic signed [SampleW-1:0] x_prev_i,
  input  logic signed [SampleW-1:0] y_prev_i,
  input  logic signed [AccW-1:0]    sum_i,
  output logic signed [SampleW-1:0] x_o,
  output logic signed [SampleW-1:0] y_o,
  output logic signed [AccW-1:0]    sum_o
);

  localparam int ProdW = SampleW + CoefW;
  localparam int TermW = ProdW + 1;

  logic signed [SampleW-1:0] x_q, x_d, y_q, y_d;
  logic signed [CoefW-1:0]   b_q, b_d, a_q, a_d;
  logic signed [TermW-1:0]   term_q, term_d;
  logic signed [AccW-1:0]    sum_q, sum_d;
  logic signed [ProdW-1:0]   prod_fwd, prod_fb;
  logic signed [TermW-1:0]   fb_sel;
  logic                      active, hit;

  assign active = CntW'(CellIdx) < n_i;
  assign hit    = (CellIdx < TapIdxRange) && (ctrl_i.tap_index == TapIdxW'(CellIdx));

  always_comb begin
    x_d = x_q;
    if (ctrl_i.clear) begin
      x_d = value_i[SampleW-1:0];
    end else if (ctrl_i.shift && active) begin
      x_d = x_prev_i;
    end

    y_d = y_q;
    if (ctrl_i.clear) begin
      y_d = value_i[SampleW-1:0];
    end else if (CellIdx == 0) begin
      // tap 0 takes the fresh output when the result is produced
      if (ctrl_i.y_load) begin
        y_d = y_prev_i;
      end
    end else if (ctrl_i.shift && ctrl_i.iir && active) begin
      y_d = y_prev_i;
    end

    b_d = b_q;
    if (ctrl_i.ld_fwd && hit) begin
      b_d = value_i[CoefW-1:0];
    end
    a_d = a_q;
    if (ctrl_i.ld_fb && hit) begin
      a_d = value_i[CoefW-1:0];
    end
  end

  assign prod_fwd = b_q * x_q;
  assign prod_fb  = a_q * y_q;

  always_comb begin
    fb_sel = '0;
    if (ctrl_i.iir && (CellIdx != 0)) begin
      fb_sel = TermW'(prod_fb);
    end
    term_d = '0;
    if (active) begin
      term_d = TermW'(prod_fwd) - fb_sel;
    end
    sum_d = sum_i + AccW'(term_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      b_q <= '0;
      a_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      b_q <= b_d;
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    sum_q  <= sum_d;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign sum_o = sum_q;

endmodule

// ----- src/fdf_round.sv -----
// Round-half-up and saturation of the accumulated sum to the sample format.
// Uses fdf_pkg for the coefficient fraction width.
module fdf_round import fdf_pkg::*; #(
  parameter int AccW    = 45,
  parameter int SampleW = 18
) (
  input  logic signed [AccW-1:0]    acc_i,
  output logic signed [SampleW-1:0] q_o,
  output logic                      sat_o
);

  localparam int RndW = AccW + 1;
  localparam int ShW  = RndW - CoefFrac;
  localparam logic signed [RndW-1:0] Half = RndW'(1 << (CoefFrac - 1));
  localparam logic signed [ShW-1:0]  Hi   = ShW'((longint'(1) << (SampleW - 1)) - 1);
  localparam logic signed [ShW-1:0]  Lo   = ShW'(-(longint'(1) << (SampleW - 1)));

  logic signed [RndW-1:0] rnd;
  logic signed [ShW-1:0]  shifted;

  always_comb begin
    rnd     = RndW'(acc_i) + Half;
    shifted = rnd[RndW-1:CoefFrac];  // floor of the arithmetic shift
    sat_o   = 1'b0;
    q_o     = shifted[SampleW-1:0];
    if (shifted > Hi) begin
      q_o   = Hi[SampleW-1:0];
      sat_o = 1'b1;
    end else if (shifted < Lo) begin
      q_o   = Lo[SampleW-1:0];
      sat_o = 1'b1;
    end
  end

endmodule

// ----- src/fir_iir_direct_form_filter.sv -----
// Top level of the direct-form FIR/IIR filter: sequencer, config registers,
// result register and the chain of fdf_cell taps. Uses fdf_pkg, fdf_if, fdf_round.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------
//  samp_i   | in  | valid / ready | command, tap_index, value
//  res_o    | out | valid / ready | filtered, saturated
//  cfg_i    | in  | valid / ready | index, data (0 taps_in_use, 1 iir_mode)
//
// Load and clear transfers leave the filter idle. A sample runs in steps: first
// the tap terms are registered, then the partial sum walks the MAX_TAPS cells.
// samp_i.ready is high only while no sample is in flight; cfg_i is always ready.
// The result register frees samp_i while a result waits; a finished sample
// holds in the last step until the result register is free.
// Reset clears histories and coefficients to zero, taps_in_use to 16, FIR mode.
module fir_iir_direct_form_filter import fdf_pkg::*; #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 18
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdf_in_if.sink    samp_i,
  fdf_out_if.source res_o,
  fdf_cfg_if.sink   cfg_i
);

  localparam int ValW = (SAMPLE_WIDTH > CoefW) ? SAMPLE_WIDTH : CoefW;
  localparam int CntW = $clog2(MAX_TAPS + 1);
  localparam int AccW = SAMPLE_WIDTH + CoefW + 2 + $clog2(MAX_TAPS);
  localparam int RunW = $clog2(MAX_TAPS + 2);
  localparam logic [RunW-1:0] RunLast = RunW'(MAX_TAPS + 1);

  state_e                         state_q, state_d;
  logic [RunW-1:0]                run_cnt_q, run_cnt_d;
  logic [CfgDataW-1:0]            taps_q, taps_d;
  logic                           iir_q, iir_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] filtered_q, filtered_d;
  logic                           sat_q, sat_d;

  logic                           in_xfer, cfg_xfer, slot_free, finish;
  cmd_e                           cmd;
  cell_ctrl_t                     ctrl;
  logic [CntW-1:0]                n_act;
  logic signed [SAMPLE_WIDTH-1:0] q_w;
  logic                           sat_w;

  logic signed [SAMPLE_WIDTH-1:0] x_w   [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] y_w   [MAX_TAPS];
  logic signed [AccW-1:0]         sum_w [MAX_TAPS];

  assign cmd       = cmd_e'(samp_i.command);
  assign in_xfer   = samp_i.valid && samp_i.ready;
  assign cfg_xfer  = cfg_i.valid && cfg_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;

  assign samp_i.ready = (state_q == StIdle);
  assign cfg_i.ready  = 1'b1;

  // zero taps acts as one, too many as MAX_TAPS
  always_comb begin
    if (taps_q == '0) begin
      n_act = CntW'(1);
    end else if (int'(taps_q) > MAX_TAPS) begin
      n_act = CntW'(MAX_TAPS);
    end else begin
      n_act = CntW'(taps_q);
    end
  end

  always_comb begin
    taps_d = taps_q;
    iir_d  = iir_q;
    if (cfg_xfer) begin
      case (cfg_reg_e'(cfg_i.index))
        RegTapsInUse: taps_d = cfg_i.data;
        RegIirMode:   iir_d  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    run_cnt_d = run_cnt_q;
    finish    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_xfer && (cmd == CmdSample)) begin
          state_d   = StRun;
          run_cnt_d = '0;
        end
      end
      StRun: begin
        if (run_cnt_q == RunLast) begin
          if (slot_free) begin
            finish  = 1'b1;
            state_d = StIdle;
          end
        end else begin
          run_cnt_d = run_cnt_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl.shift     = in_xfer && (cmd == CmdSample);
    ctrl.clear     = in_xfer && (cmd == CmdClear);
    ctrl.ld_fwd    = in_xfer && (cmd == CmdLoadFwd);
    ctrl.ld_fb     = in_xfer && (cmd == CmdLoadFb);
    ctrl.y_load    = finish;
    ctrl.iir       = iir_q;
    ctrl.tap_index = samp_i.tap_index;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    filtered_d  = filtered_q;
    sat_d       = sat_q;
    if (finish) begin
      out_valid_d = 1'b1;
      filtered_d  = q_w;
      sat_d       = sat_w;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      run_cnt_q   <= '0;
      taps_q      <= CfgDataW'(TapsResetVal);
      iir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_cnt_q   <= run_cnt_d;
      taps_q      <= taps_d;
      iir_q       <= iir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    filtered_q <= filtered_d;
    sat_q      <= sat_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.filtered  = filtered_q;
  assign res_o.saturated = sat_q;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      fdf_cell #(
        .SampleW (SAMPLE_WIDTH),
        .ValW    (ValW),
        .AccW    (AccW),
        .CntW    (CntW),
        .CellIdx (k)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .value_i  (ValW'(samp_i.value)),
        .n_i      (n_act),
        .x_prev_i (samp_i.value[SAMPLE_WIDTH-1:0]),
        .y_prev_i (q_w),
        .sum_i    ('0),
        .x_o      (x_w[k]),
        .y_o      (y_w[k]),
        .sum_o    (sum_w[k])
      );
    end else begin : g_body
      fdf_cell #(
        .SampleW (SAMPLE_WIDTH),
        .ValW    (ValW),
        .AccW    (AccW),
        .CntW    (CntW),
        .CellIdx (k)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .value_i  (ValW'(samp_i.value)),
        .n_i      (n_act),
        .x_prev_i (x_w[k-1]),
        .y_prev_i (y_w[k-1]),
        .sum_i    (sum_w[k-1]),
        .x_o      (x_w[k]),
        .y_o      (y_w[k]),
        .sum_o    (sum_w[k])
      );
    end
  end

  fdf_round #(
    .AccW    (AccW),
    .SampleW (SAMPLE_WIDTH)
  ) u_round (
    .acc_i (sum_w[MAX_TAPS-1]),
    .q_o   (q_w),
    .sat_o (sat_w)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for fir_iir_direct_form_filter: directed table plus
// random command traffic, each result checked against an in-bench filter model.
// Depends on fdf_pkg, the fdf_if interfaces and the filter RTL.
module tb;
  import fdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxTaps       = 128;
  localparam int SampleW       = 18;
  localparam int LatencyCycles = MaxTaps + 8;
  localparam int CycleLimit    = 1_200_000;
  localparam int PhaseCount    = 9;
  localparam int PhaseItems    = 120;
  // register index that the block does not decode
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic signed [SampleW-1:0] filtered;
    logic                      saturated;
  } result_t;

  typedef enum {RowItem, RowReg} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    cmd_e                cmd;
    int                  idx;
    int                  val;
    logic [CfgIdxW-1:0]  reg_idx;
    int                  reg_data;
    bit                  known;
    int                  exp_filtered;
    bit                  exp_sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fdf_in_if  #(.ValW(SampleW))    samp ();
  fdf_out_if #(.SampleW(SampleW)) res ();
  fdf_cfg_if                      cfg ();

  fir_iir_direct_form_filter #(
    .MAX_TAPS    (MaxTaps),
    .SAMPLE_WIDTH(SampleW)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .samp_i(samp),
    .res_o (res),
    .cfg_i (cfg)
  );

  always #2 clk = ~clk;

  // filter model state
  logic signed [SampleW-1:0] x_hist [MaxTaps];
  logic signed [SampleW-1:0] y_hist [MaxTaps];
  logic signed [CoefW-1:0]   ff_coef[MaxTaps];
  logic signed [CoefW-1:0]   fb_coef[MaxTaps];
  logic [CfgDataW-1:0]       taps_reg;
  logic                      iir_reg;

  result_t outputs_due[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      quiet;
  int      stall_left = 0;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int active_taps();
    if (taps_reg == 0) return 1;
    if (int'(taps_reg) > MaxTaps) return MaxTaps;
    return int'(taps_reg);
  endfunction

  // Updates the model for one accepted command; returns 1 when it yields a result
  function automatic bit filter_step(input cmd_e c, input logic [TapIdxW-1:0] idx,
                                     input logic signed [SampleW-1:0] v,
                                     output result_t r);
    longint acc, q, hi, lo;
    int     n;
    r = '0;
    case (c)
      CmdLoadFwd: begin
        ff_coef[idx] = v;
        return 1'b0;
      end
      CmdLoadFb: begin
        fb_coef[idx] = v;
        return 1'b0;
      end
      CmdClear: begin
        for (int i = 0; i < MaxTaps; i++) begin
          x_hist[i] = v;
          y_hist[i] = v;
        end
        return 1'b0;
      end
      default: ;
    endcase
    n = active_taps();
    for (int i = n - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    if (iir_reg)
      for (int i = n - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    x_hist[0] = v;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc += longint'(ff_coef[i]) * longint'(x_hist[i]);
      if (iir_reg && i > 0) acc -= longint'(fb_coef[i]) * longint'(y_hist[i]);
    end
    // round half up, then floor
    q  = (acc + (longint'(1) << (CoefFrac - 1))) >>> CoefFrac;
    hi = (longint'(1) << (SampleW - 1)) - 1;
    lo = -hi - 1;
    r.saturated = 1'b0;
    if (q > hi) begin
      q = hi;
      r.saturated = 1'b1;
    end else if (q < lo) begin
      q = lo;
      r.saturated = 1'b1;
    end
    y_hist[0]  = q[SampleW-1:0];
    r.filtered = q[SampleW-1:0];
    return 1'b1;
  endfunction

  function automatic int sender_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int receiver_stall();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic stim_row_t item_row(cmd_e c, int idx, int v, bit known = 0,
                                         int ef = 0, bit es = 0);
    stim_row_t row;
    row = '{RowItem, c, idx, v, RegTapsInUse, 0, known, ef, es};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] ri, int data);
    stim_row_t row;
    row = '{RowReg, CmdSample, 0, 0, ri, data, 1'b0, 0, 1'b0};
    return row;
  endfunction

  // Leaves valid high after the transfer; the next negedge either loads the
  // next item or lowers valid.
  task automatic send_item(cmd_e c, logic [TapIdxW-1:0] idx, logic signed [SampleW-1:0] v,
                           bit known, result_t known_res, int gap);
    result_t r;
    @(negedge clk);
    samp.valid     <= 1'b1;
    samp.command   <= c;
    samp.tap_index <= idx;
    samp.value     <= v;
    do @(posedge clk); while (!samp.ready);
    if (filter_step(c, idx, v, r))
      outputs_due.insert(outputs_due.size(), known ? known_res : r);
    if (gap > 0) begin
      @(negedge clk);
      samp.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending, wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    samp.valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] ri, logic [CfgDataW-1:0] data);
    settle();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= ri;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (ri == RegTapsInUse) taps_reg = data;
    else if (ri == RegIirMode) iir_reg = data[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!quiet && stall_left == 0) stall_left = receiver_stall();
    if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && res.valid && res.ready) begin
      if (outputs_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing outstanding", res.filtered));
      end else begin
        want = outputs_due.pop_front();
        if (res.filtered !== want.filtered)
          flag_mismatch($sformatf("filtered %0d, want %0d", res.filtered, want.filtered));
        if (res.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %0b, want %0b", res.saturated,
                                  want.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fir_iir_direct_form_filter verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t                 directed[$];
    stim_row_t                 row;
    result_t                   typed;
    cmd_e                      c;
    logic [TapIdxW-1:0]        idx;
    logic signed [SampleW-1:0] v;
    int                        roll;
    int                        tv;

    quiet          = 1'b0;
    rst_n          = 1'b0;
    samp.valid     = 1'b0;
    samp.command   = CmdSample;
    samp.tap_index = '0;
    samp.value     = '0;
    cfg.valid      = 1'b0;
    cfg.index      = RegTapsInUse;
    cfg.data       = '0;
    for (int i = 0; i < MaxTaps; i++) begin
      x_hist[i]  = '0;
      y_hist[i]  = '0;
      ff_coef[i] = '0;
      fb_coef[i] = '0;
    end
    taps_reg = CfgDataW'(TapsResetVal);
    iir_reg  = 1'b0;

    // after reset all coefficients are zero
    directed = {directed, item_row(CmdSample, 0, 131071, 1, 0, 0)};
    directed = {directed, item_row(CmdSample, 127, -131072, 1, 0, 0)};
    // only tap 0 weighted: extremes clip
    directed = {directed, item_row(CmdLoadFwd, 0, 131071)};
    directed = {directed, item_row(CmdSample, 0, 131071, 1, 131071, 1)};
    directed = {directed, item_row(CmdSample, 0, -131072, 1, -131072, 1)};
    directed = {directed, item_row(CmdLoadFwd, 0, -131072)};
    directed = {directed, item_row(CmdSample, 0, -131072, 1, 131071, 1)};
    // gain one half: ties round toward plus infinity
    directed = {directed, item_row(CmdLoadFwd, 0, 16384)};
    directed = {directed, item_row(CmdSample, 0, 1, 1, 1, 0)};
    directed = {directed, item_row(CmdSample, 0, -1, 1, 0, 0)};
    directed = {directed, item_row(CmdSample, 0, -2, 1, -1, 0)};
    directed = {directed, item_row(CmdLoadFwd, 127, -32768)};
    directed = {directed, item_row(CmdLoadFwd, 1, 24576)};
    directed = {directed, item_row(CmdLoadFb, 1, 16384)};
    directed = {directed, item_row(CmdLoadFb, 127, 131071)};
    directed = {directed, item_row(CmdLoadFb, 0, -131072)};
    directed = {directed, reg_row(RegIirMode, 8'hFF)};
    directed = {directed, item_row(CmdSample, 5, 50000)};
    directed = {directed, item_row(CmdSample, 9, -77777)};
    directed = {directed, item_row(CmdClear, 0, 131071)};
    directed = {directed, item_row(CmdSample, 0, 0)};
    directed = {directed, reg_row(RegTapsInUse, 0)};
    directed = {directed, item_row(CmdSample, 0, -5)};
    directed = {directed, reg_row(RegTapsInUse, 255)};
    directed = {directed, item_row(CmdClear, 0, -131072)};
    directed = {directed, item_row(CmdSample, 0, 131071)};
    directed = {directed, reg_row(RegSpare, 8'h5A)};
    directed = {directed, reg_row(RegIirMode, 8'hFE)};
    directed = {directed, reg_row(RegTapsInUse, 128)};
    directed = {directed, item_row(CmdSample, 0, -131072)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      row = directed[k];
      if (row.kind == RowReg) begin
        write_reg(row.reg_idx, CfgDataW'(row.reg_data));
      end else begin
        typed.filtered  = SampleW'(row.exp_filtered);
        typed.saturated = row.exp_sat;
        send_item(row.cmd, TapIdxW'(row.idx), SampleW'(row.val), row.known, typed,
                  sender_gap());
      end
    end

    typed = '0;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       tv = 1;
        1:       tv = 0;
        2:       tv = 255;
        3:       tv = 128;
        default: tv = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 16)
                                                  : $urandom_range(0, 255);
      endcase
      write_reg(RegTapsInUse, CfgDataW'(tv));
      write_reg(RegIirMode, CfgDataW'(($urandom_range(0, 127) << 1) | (p & 1)));
      if (p % 3 == 1) write_reg(RegSpare, CfgDataW'($urandom));
      quiet = (p % 4 == 2);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 4 && k == PhaseItems / 2) settle();
        roll = $urandom_range(0, 99);
        c = (roll < 70) ? CmdSample : (roll < 82) ? CmdLoadFwd
          : (roll < 94) ? CmdLoadFb : CmdClear;
        // loads aim mostly at the active taps
        idx = ($urandom_range(0, 9) < 7) ? TapIdxW'($urandom_range(0, active_taps() - 1))
                                         : TapIdxW'($urandom);
        if (c == CmdLoadFwd || c == CmdLoadFb) begin
          // mostly small coefficients so the recursion does not pin at the rails
          v = ($urandom_range(0, 3) != 0) ? SampleW'(int'($urandom_range(0, 8191)) - 4096)
                                          : SampleW'($urandom);
        end else if (c == CmdClear && $urandom_range(0, 1) == 0) begin
          v = '0;
        end else begin
          v = ($urandom_range(0, 9) < 6) ? SampleW'($urandom)
                                         : SampleW'(int'($urandom_range(0, 4095)) - 2048);
        end
        send_item(c, idx, v, 1'b0, typed, sender_gap());
      end
      quiet = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("fir_iir_direct_form_filter verification clean");
    end else begin
      $display("fir_iir_direct_form_filter verification failed");
    end
    $finish;
  end

endmodule
